>>> src/lc3s_pkg.sv
// Shared types and constants for the LC-3 instruction step core.
// Used by lc3s_front, lc3s_back and lc3_instruction_step.
`timescale 1ns / 1ps

package lc3s_pkg;

  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  localparam logic [15:0] KBSR_ADDR = 16'hFE00;
  localparam logic [15:0] KBDR_ADDR = 16'hFE02;
  localparam logic [15:0] PC_RESET  = 16'h3000;

  localparam logic [2:0] FLAG_P = 3'd1;
  localparam logic [2:0] FLAG_Z = 3'd2;
  localparam logic [2:0] FLAG_N = 3'd4;

  // item kinds, straight from the op field
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_EXEC    = 2'd2;
  localparam logic [1:0] KIND_NOP     = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // opcodes
  localparam logic [3:0] OPC_BR   = 4'h0;
  localparam logic [3:0] OPC_ADD  = 4'h1;
  localparam logic [3:0] OPC_LD   = 4'h2;
  localparam logic [3:0] OPC_ST   = 4'h3;
  localparam logic [3:0] OPC_JSR  = 4'h4;
  localparam logic [3:0] OPC_AND  = 4'h5;
  localparam logic [3:0] OPC_LDR  = 4'h6;
  localparam logic [3:0] OPC_STR  = 4'h7;
  localparam logic [3:0] OPC_NOT  = 4'h9;
  localparam logic [3:0] OPC_LDI  = 4'hA;
  localparam logic [3:0] OPC_STI  = 4'hB;
  localparam logic [3:0] OPC_JMP  = 4'hC;
  localparam logic [3:0] OPC_LEA  = 4'hE;
  localparam logic [3:0] OPC_TRAP = 4'hF;

  // built-in trap vectors
  localparam logic [7:0] VEC_GETC = 8'h20;
  localparam logic [7:0] VEC_OUT  = 8'h21;
  localparam logic [7:0] VEC_IN   = 8'h23;
  localparam logic [7:0] VEC_HALT = 8'h25;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] load_address;
    logic [15:0] load_data;
    logic        key_ready;
    logic [7:0]  key_char;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        char_valid;
    logic [7:0]  char_out;
    logic        trap_taken;
    logic [7:0]  trap_code;
    logic [15:0] r0_value;
    logic [15:0] next_pc;
  } result_t;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    if (v == 16'd0) begin
      return FLAG_Z;
    end else if (v[15]) begin
      return FLAG_N;
    end else begin
      return FLAG_P;
    end
  endfunction

endpackage

>>> src/lc3s_front.sv
// Front end: accepts stream transfers, classifies them and holds them
// in a two-entry queue for the back end. Depends on lc3s_pkg.
`timescale 1ns / 1ps

module lc3s_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_op,
  input  logic [15:0]    in_load_address,
  input  logic [15:0]    in_load_data,
  input  logic           in_key_ready,
  input  logic [7:0]     in_key_char,
  output logic           q_valid,
  output lc3s_pkg::item_t q_item,
  input  logic           q_pop
);
  import lc3s_pkg::*;

  item_t       q [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  item_t       item_in;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = q[rptr];

  always_comb begin
    item_in.kind = in_op;
    case (in_op)
      KIND_LOAD:    item_in.kind = KIND_LOAD;
      KIND_RESTART: item_in.kind = KIND_RESTART;
      KIND_EXEC:    item_in.kind = KIND_EXEC;
      default:      item_in.kind = KIND_NOP;
    endcase
    item_in.load_address = in_load_address;
    item_in.load_data    = in_load_data;
    item_in.key_ready    = in_key_ready;
    item_in.key_char     = in_key_char;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/lc3s_back.sv
// Back end: sequencer that executes queued items against the single-port
// main memory and the register file, and holds the result register.
// Depends on lc3s_pkg.
`timescale 1ns / 1ps

module lc3s_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              q_valid,
  input  lc3s_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              res_valid,
  output lc3s_pkg::result_t res,
  input  logic              res_ready
);
  import lc3s_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_KBDR = 3'd2;
  localparam logic [2:0] S_USE  = 3'd3;
  localparam logic [2:0] S_EX   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] mem_q;

  logic [15:0] regs [8];
  logic [2:0]  state, state_next;
  logic [1:0]  phase, phase_next;
  logic [15:0] pc, pc_next;
  logic [2:0]  flags, flags_next;
  logic        stopped, stopped_next;
  logic [15:0] start_addr;
  logic [15:0] ir, ir_next;
  logic [15:0] ra, ra_next;
  logic [15:0] rb, rb_next;
  logic [15:0] rd_addr, rd_addr_next;
  logic [15:0] wa, wa_next;
  logic [15:0] rval, rval_next;
  logic        from_mem, from_mem_next;
  logic        rd_oor, rd_oor_next;
  logic        kr, kr_next;
  logic [7:0]  kc, kc_next;

  logic        mem_we, mem_re;
  logic [15:0] mem_addr, mem_wdata;
  logic        wa_en, w7_en;
  logic [2:0]  wa_idx;
  logic [15:0] wa_val;
  logic        fin, go, out_free;
  result_t     res_next;
  logic [15:0] val;
  logic [3:0]  opc, vopc;
  logic [15:0] off9, off6, off11, imm5, alu_b, alu_r;
  logic        is_store;

  assign out_free = !res_valid || res_ready;
  assign go       = !fin || out_free;
  assign val      = from_mem ? (rd_oor ? 16'd0 : mem_q) : rval;
  assign opc      = ir[15:12];
  assign vopc     = val[15:12];
  assign off9     = {{7{ir[8]}}, ir[8:0]};
  assign off6     = {{10{ir[5]}}, ir[5:0]};
  assign off11    = {{5{ir[10]}}, ir[10:0]};
  assign imm5     = {{11{ir[4]}}, ir[4:0]};
  assign alu_b    = ir[5] ? imm5 : rb;
  assign alu_r    = (opc == OPC_ADD) ? ra + alu_b : ra & alu_b;
  assign is_store = (vopc == OPC_ST) || (vopc == OPC_STI) || (vopc == OPC_STR);

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    pc_next       = pc;
    flags_next    = flags;
    stopped_next  = stopped;
    ir_next       = ir;
    ra_next       = ra;
    rb_next       = rb;
    rd_addr_next  = rd_addr;
    wa_next       = wa;
    rval_next     = rval;
    from_mem_next = from_mem;
    rd_oor_next   = rd_oor;
    kr_next       = kr;
    kc_next       = kc;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = rd_addr;
    mem_wdata     = rb;
    wa_en         = 1'b0;
    wa_idx        = ir[11:9];
    wa_val        = 16'd0;
    w7_en         = 1'b0;
    fin           = 1'b0;
    q_pop         = 1'b0;
    res_next      = '0;

    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          kr_next = q_item.key_ready;
          kc_next = q_item.key_char;
          case (q_item.kind)
            KIND_LOAD: begin
              fin       = 1'b1;
              mem_we    = 1'b1;
              mem_addr  = q_item.load_address;
              mem_wdata = q_item.load_data;
            end
            KIND_RESTART: begin
              fin          = 1'b1;
              pc_next      = start_addr;
              flags_next   = FLAG_Z;
              stopped_next = 1'b0;
            end
            KIND_EXEC: begin
              if (stopped) begin
                fin             = 1'b1;
                res_next.status = ST_IGNORED;
              end else begin
                rd_addr_next = pc;
                phase_next   = 2'd0;
                state_next   = S_RD;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_RD: begin
        // keyboard status read writes status (and data) back into memory
        if (rd_addr == KBSR_ADDR) begin
          mem_we        = 1'b1;
          mem_addr      = KBSR_ADDR;
          mem_wdata     = kr ? 16'h8000 : 16'h0000;
          rval_next     = kr ? 16'h8000 : 16'h0000;
          from_mem_next = 1'b0;
          state_next    = kr ? S_KBDR : S_USE;
        end else begin
          mem_re        = 1'b1;
          from_mem_next = 1'b1;
          rd_oor_next   = ({1'b0, rd_addr} >= 17'(MEM_WORDS));
          state_next    = S_USE;
        end
      end
      S_KBDR: begin
        mem_we     = 1'b1;
        mem_addr   = KBDR_ADDR;
        mem_wdata  = {8'd0, kc};
        state_next = S_USE;
      end
      S_USE: begin
        case (phase)
          2'd0: begin
            ir_next    = val;
            ra_next    = regs[val[8:6]];
            rb_next    = is_store ? regs[val[11:9]] : regs[val[2:0]];
            pc_next    = pc + 16'd1;
            state_next = S_EX;
          end
          2'd1: begin
            case (opc)
              OPC_LDI: begin
                rd_addr_next = val;
                phase_next   = 2'd2;
                state_next   = S_RD;
              end
              OPC_STI: begin
                wa_next    = val;
                state_next = S_WR;
              end
              default: begin
                fin        = 1'b1;
                wa_en      = 1'b1;
                wa_val     = val;
                flags_next = flags_of(val);
              end
            endcase
          end
          default: begin
            fin        = 1'b1;
            wa_en      = 1'b1;
            wa_val     = val;
            flags_next = flags_of(val);
          end
        endcase
      end
      S_EX: begin
        case (opc)
          OPC_ADD, OPC_AND: begin
            fin        = 1'b1;
            wa_en      = 1'b1;
            wa_val     = alu_r;
            flags_next = flags_of(alu_r);
          end
          OPC_NOT: begin
            fin        = 1'b1;
            wa_en      = 1'b1;
            wa_val     = ~ra;
            flags_next = flags_of(~ra);
          end
          OPC_BR: begin
            fin = 1'b1;
            if ((ir[11:9] & flags) != 3'd0) begin
              pc_next = pc + off9;
            end
          end
          OPC_JMP: begin
            fin     = 1'b1;
            pc_next = ra;
          end
          OPC_JSR: begin
            fin     = 1'b1;
            w7_en   = 1'b1;
            pc_next = ir[11] ? pc + off11 : ra;
          end
          OPC_LD, OPC_LDI, OPC_STI: begin
            rd_addr_next = pc + off9;
            phase_next   = 2'd1;
            state_next   = S_RD;
          end
          OPC_LDR: begin
            rd_addr_next = ra + off6;
            phase_next   = 2'd1;
            state_next   = S_RD;
          end
          OPC_LEA: begin
            fin        = 1'b1;
            wa_en      = 1'b1;
            wa_val     = pc + off9;
            flags_next = flags_of(pc + off9);
          end
          OPC_ST: begin
            wa_next    = pc + off9;
            state_next = S_WR;
          end
          OPC_STR: begin
            wa_next    = ra + off6;
            state_next = S_WR;
          end
          OPC_TRAP: begin
            fin                 = 1'b1;
            w7_en               = 1'b1;
            res_next.trap_taken = 1'b1;
            res_next.trap_code  = ir[7:0];
            case (ir[7:0])
              VEC_GETC: begin
                wa_en      = 1'b1;
                wa_idx     = 3'd0;
                wa_val     = {8'd0, kc};
                flags_next = flags_of({8'd0, kc});
              end
              VEC_OUT: begin
                res_next.char_valid = 1'b1;
                res_next.char_out   = regs[0][7:0];
              end
              VEC_IN: begin
                wa_en               = 1'b1;
                wa_idx              = 3'd0;
                wa_val              = {8'd0, kc};
                flags_next          = flags_of({8'd0, kc});
                res_next.char_valid = 1'b1;
                res_next.char_out   = kc;
              end
              VEC_HALT: begin
                res_next.status = ST_HALT;
                stopped_next    = 1'b1;
              end
              default: ;
            endcase
          end
          default: begin
            // RTI and the reserved opcode
            fin             = 1'b1;
            res_next.status = ST_ILLEGAL;
            stopped_next    = 1'b1;
          end
        endcase
      end
      S_WR: begin
        fin       = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = wa;
        mem_wdata = rb;
      end
      default: state_next = S_IDLE;
    endcase

    if (fin) begin
      state_next = S_IDLE;
    end
    res_next.r0_value = (wa_en && wa_idx == 3'd0) ? wa_val : regs[0];
    res_next.next_pc  = pc_next;
    if (!go) begin
      q_pop = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && mem_we && ({1'b0, mem_addr} < 17'(MEM_WORDS))) begin
      mem[mem_addr[MEM_AW-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_addr[MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        regs[i] <= 16'd0;
      end
    end else if (go) begin
      if (w7_en) begin
        regs[7] <= pc;
      end
      if (wa_en) begin
        regs[wa_idx] <= wa_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= PC_RESET;
    end else if (cfg_we) begin
      start_addr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 2'd0;
      pc        <= PC_RESET;
      flags     <= FLAG_Z;
      stopped   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (go) begin
        state   <= state_next;
        phase   <= phase_next;
        pc      <= pc_next;
        flags   <= flags_next;
        stopped <= stopped_next;
      end
      if (fin && go) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ir       <= ir_next;
      ra       <= ra_next;
      rb       <= rb_next;
      rd_addr  <= rd_addr_next;
      wa       <= wa_next;
      rval     <= rval_next;
      from_mem <= from_mem_next;
      rd_oor   <= rd_oor_next;
      kr       <= kr_next;
      kc       <= kc_next;
    end
    if (fin && go) begin
      res <= res_next;
    end
  end

endmodule

>>> src/lc3_instruction_step.sv
// LC-3 instruction step core, top level: stream ports, front queue, back end.
// Depends on lc3s_pkg, lc3s_front and lc3s_back.
`timescale 1ns / 1ps

// Each input transfer loads a memory word, restarts at start_address, or
// executes one LC-3 instruction; every transfer yields one result transfer.
// The front queue (two entries) keeps accepting, while not full, as the back
// end works and a finished result waits in the output register. Cost per item
// is set by the single-port main memory (one access per cycle, held while a
// finished result waits) and taking the item from the queue: an execute fetches
// (S_RD), decodes (S_USE) and executes (S_EX); LD/LDR add a data read, LDI a
// pointer and a data read, ST/STR a write (S_WR), STI a pointer read and a write.
// A keyboard status read with a key waiting writes it into the data register.

module lc3_instruction_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,     // start_address
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // load_address, load_data, key_ready, key_char, pad
  input  logic [1:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // char_valid, char_out, trap_taken, trap_code,
                                     // r0_value, next_pc, pad
  output logic [1:0]  m_axis_tuser   // status
);
  import lc3s_pkg::*;

  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  result_t res;

  lc3s_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .in_op           (s_axis_tuser),
    .in_load_address (s_axis_tdata[15:0]),
    .in_load_data    (s_axis_tdata[31:16]),
    .in_key_ready    (s_axis_tdata[32]),
    .in_key_char     (s_axis_tdata[40:33]),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  lc3s_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (m_axis_tvalid),
    .res       (res),
    .res_ready (m_axis_tready)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {6'd0, res.next_pc, res.r0_value, res.trap_code,
                         res.trap_taken, res.char_out, res.char_valid};

endmodule
